[rtl/core/hsv2rgb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv2rgb_pkg
// Types and fixed constants shared by the HSV to RGB converter.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  localparam int HUE_W  = 16;
  localparam int CH_W   = 8;
  localparam int FRAC_W = 10;
  localparam int SEC_W  = 3;

  typedef logic signed [HUE_W-1:0] hue_t;
  typedef logic [CH_W-1:0]         chan_t;
  typedef logic [FRAC_W-1:0]       frac_t;
  typedef logic [SEC_W-1:0]        sector_t;

  // Six full turns lift any 16-bit hue to a non-negative value.
  localparam logic [16:0] HUE_OFFSET = 17'd34560;
  localparam logic [9:0]  HUE_SECTOR = 10'd960;
  localparam logic [7:0]  UNIT       = 8'd255;
  localparam logic [17:0] DEN_Q      = 18'd244800;

  // Reciprocals: m/15, k/6, x/255 (16-bit x), y/3825 (20-bit y).
  localparam logic [12:0] RECIP_15   = 13'd4370;
  localparam logic [5:0]  RECIP_6    = 6'd43;
  localparam logic [15:0] RECIP_255  = 16'h8081;
  localparam logic [20:0] RECIP_3825 = 21'd1122868;

  // Hue sectors.
  localparam sector_t SEC_RED_YEL = 3'd0;
  localparam sector_t SEC_YEL_GRN = 3'd1;
  localparam sector_t SEC_GRN_CYN = 3'd2;
  localparam sector_t SEC_CYN_BLU = 3'd3;
  localparam sector_t SEC_BLU_MAG = 3'd4;

endpackage

[rtl/core/hsv_to_rgb_pixel_converter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_converter
// Fixed-point HSV to RGB conversion, seven-stage pipeline, one item per clock.
// ----------------------------------------------------------------------------
// Channel   Handshake      Fields
// input     start / busy   hue (s16), saturation (u8), brightness (u8)
// result    done           red (u8), green (u8), blue (u8)
//
// One item accepted per clock; its result is driven with done from the output
// register that follows stages 1 to 6. The depth is set
// by the chain of reciprocal multipliers (hue split, channel products, divide
// by 255 and by 244800).
// busy stays low; the pipeline never stalls since results cannot be held.
// Reset clears the stage valid bits and done only.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_converter (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  hsv2rgb_pkg::hue_t   hue,
  input  hsv2rgb_pkg::chan_t  saturation,
  input  hsv2rgb_pkg::chan_t  brightness,
  output logic                done,
  output hsv2rgb_pkg::chan_t  red,
  output hsv2rgb_pkg::chan_t  green,
  output hsv2rgb_pkg::chan_t  blue
);
  import hsv2rgb_pkg::*;

  logic [5:0] vld;

  // stage 1: lifted hue split by 64
  logic [16:0] hue_lift;
  logic [10:0] s1_m;
  logic [5:0]  s1_lo;
  chan_t       s1_s, s1_v;

  // stage 2: quotient by 960
  logic [23:0] s1_kprod;
  logic [6:0]  s2_k;
  logic [10:0] s2_m;
  logic [5:0]  s2_lo;
  chan_t       s2_s, s2_v;

  // stage 3: sector and remainder
  logic [10:0] s2_k15;
  logic [10:0] s2_rem;
  logic [11:0] s2_k43;
  logic [3:0]  s2_k6;
  logic [6:0]  s2_sec;
  frac_t       s3_f;
  sector_t     s3_sec;
  chan_t       s3_s, s3_v;

  // stage 4: saturation products
  logic [17:0] s4_sf, s4_sg;
  logic [15:0] s4_pn;
  sector_t     s4_sec;
  logic        s4_sz;
  chan_t       s4_v;

  // stage 5: numerators and p
  logic [17:0] s4_qn, s4_tn;
  logic [31:0] s4_pprod;
  logic [25:0] s5_yq, s5_yt;
  chan_t       s5_p;
  sector_t     s5_sec;
  logic        s5_sz;
  chan_t       s5_v;

  // stage 6: q and t
  logic [40:0] s5_qprod, s5_tprod;
  chan_t       s6_p, s6_q, s6_t;
  sector_t     s6_sec;
  logic        s6_sz;
  chan_t       s6_v;

  chan_t red_next, green_next, blue_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld  <= '0;
      done <= 1'b0;
    end else begin
      vld  <= {vld[4:0], start & ~busy};
      done <= vld[5];
    end
  end

  assign hue_lift = {hue[HUE_W-1], hue} + HUE_OFFSET;

  always_ff @(posedge clk) begin
    s1_m  <= hue_lift[16:6];
    s1_lo <= hue_lift[5:0];
    s1_s  <= saturation;
    s1_v  <= brightness;
  end

  assign s1_kprod = 24'(s1_m) * 24'(RECIP_15);

  always_ff @(posedge clk) begin
    s2_k  <= s1_kprod[22:16];
    s2_m  <= s1_m;
    s2_lo <= s1_lo;
    s2_s  <= s1_s;
    s2_v  <= s1_v;
  end

  assign s2_k15 = 11'(s2_k) * 11'd15;
  assign s2_rem = s2_m - s2_k15;
  assign s2_k43 = 12'(s2_k) * 12'(RECIP_6);
  assign s2_k6  = s2_k43[11:8];
  assign s2_sec = s2_k - 7'(s2_k6) * 7'd6;

  always_ff @(posedge clk) begin
    s3_f   <= {s2_rem[3:0], s2_lo};
    s3_sec <= s2_sec[SEC_W-1:0];
    s3_s   <= s2_s;
    s3_v   <= s2_v;
  end

  always_ff @(posedge clk) begin
    s4_sf  <= 18'(s3_s) * 18'(s3_f);
    s4_sg  <= 18'(s3_s) * 18'(HUE_SECTOR - s3_f);
    s4_pn  <= 16'(s3_v) * 16'(UNIT - s3_s);
    s4_sec <= s3_sec;
    s4_sz  <= (s3_s == '0);
    s4_v   <= s3_v;
  end

  assign s4_qn    = DEN_Q - s4_sf;
  assign s4_tn    = DEN_Q - s4_sg;
  assign s4_pprod = 32'(s4_pn) * 32'(RECIP_255);

  always_ff @(posedge clk) begin
    s5_yq  <= 26'(s4_v) * 26'(s4_qn);
    s5_yt  <= 26'(s4_v) * 26'(s4_tn);
    s5_p   <= s4_pprod[30:23];
    s5_sec <= s4_sec;
    s5_sz  <= s4_sz;
    s5_v   <= s4_v;
  end

  // y / 244800 = (y >> 6) / 3825
  assign s5_qprod = 41'(s5_yq[25:6]) * 41'(RECIP_3825);
  assign s5_tprod = 41'(s5_yt[25:6]) * 41'(RECIP_3825);

  always_ff @(posedge clk) begin
    s6_q   <= s5_qprod[39:32];
    s6_t   <= s5_tprod[39:32];
    s6_p   <= s5_p;
    s6_sec <= s5_sec;
    s6_sz  <= s5_sz;
    s6_v   <= s5_v;
  end

  always_comb begin
    red_next   = s6_v;
    green_next = s6_p;
    blue_next  = s6_q;
    if (s6_sz) begin
      red_next   = s6_v;
      green_next = s6_v;
      blue_next  = s6_v;
    end else begin
      case (s6_sec)
        SEC_RED_YEL: begin
          red_next = s6_v; green_next = s6_t; blue_next = s6_p;
        end
        SEC_YEL_GRN: begin
          red_next = s6_q; green_next = s6_v; blue_next = s6_p;
        end
        SEC_GRN_CYN: begin
          red_next = s6_p; green_next = s6_v; blue_next = s6_t;
        end
        SEC_CYN_BLU: begin
          red_next = s6_p; green_next = s6_q; blue_next = s6_v;
        end
        SEC_BLU_MAG: begin
          red_next = s6_t; green_next = s6_p; blue_next = s6_v;
        end
        default: begin
          red_next = s6_v; green_next = s6_p; blue_next = s6_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    red   <= red_next;
    green <= green_next;
    blue  <= blue_next;
  end

endmodule

[test/hsv_to_rgb_pixel_converter_check.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_converter_check
// Watches the item and result channels of the HSV to RGB converter. It works
// out the expected RGB triple for every accepted item and compares each
// result strobe, channel by channel, with the oldest expected pixel.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_converter_check (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                busy,
  input  hsv2rgb_pkg::hue_t   hue,
  input  hsv2rgb_pkg::chan_t  saturation,
  input  hsv2rgb_pkg::chan_t  brightness,
  input  logic                done,
  input  hsv2rgb_pkg::chan_t  red,
  input  hsv2rgb_pkg::chan_t  green,
  input  hsv2rgb_pkg::chan_t  blue,
  output int                  mismatches,
  output int                  in_flight
);
  import hsv2rgb_pkg::*;

  localparam int HUE_TURN = 6 * int'(HUE_SECTOR);

  typedef struct packed {
    hue_t  hue;
    chan_t sat;
    chan_t val;
    chan_t r;
    chan_t g;
    chan_t b;
  } pixel_t;

  pixel_t expected_pixels[$];

  function automatic pixel_t rgb_from_hsv(hue_t h_in, chan_t s_in, chan_t v_in);
    int      h;
    int      s;
    int      v;
    int      f;
    int      den;
    int      p;
    int      q;
    int      t;
    sector_t sec;
    pixel_t  px;
    px.hue = h_in;
    px.sat = s_in;
    px.val = v_in;
    h = int'(h_in) % HUE_TURN;
    if (h < 0) h += HUE_TURN;
    s = int'(s_in);
    v = int'(v_in);
    if (s == 0) begin
      px.r = v_in;
      px.g = v_in;
      px.b = v_in;
    end else begin
      den = int'(DEN_Q);
      sec = sector_t'(h / int'(HUE_SECTOR));
      f = h % int'(HUE_SECTOR);
      p = v * (int'(UNIT) - s) / int'(UNIT);
      q = v * (den - s * f) / den;
      t = v * (den - s * (int'(HUE_SECTOR) - f)) / den;
      case (sec)
        SEC_RED_YEL: begin px.r = chan_t'(v); px.g = chan_t'(t); px.b = chan_t'(p); end
        SEC_YEL_GRN: begin px.r = chan_t'(q); px.g = chan_t'(v); px.b = chan_t'(p); end
        SEC_GRN_CYN: begin px.r = chan_t'(p); px.g = chan_t'(v); px.b = chan_t'(t); end
        SEC_CYN_BLU: begin px.r = chan_t'(p); px.g = chan_t'(q); px.b = chan_t'(v); end
        SEC_BLU_MAG: begin px.r = chan_t'(t); px.g = chan_t'(p); px.b = chan_t'(v); end
        default:     begin px.r = chan_t'(v); px.g = chan_t'(p); px.b = chan_t'(q); end
      endcase
    end
    return px;
  endfunction

  always @(posedge clk) begin
    pixel_t exp_px;
    chan_t  want[3];
    chan_t  got[3];
    string  name[3];
    name = '{"red", "green", "blue"};
    if (!rst && start && !busy) begin
      expected_pixels.push_back(rgb_from_hsv(hue, saturation, brightness));
    end
    if (!rst && done) begin
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result expected none actual r=%0d g=%0d b=%0d",
                 $time, red, green, blue);
        mismatches = mismatches + 1;
      end else begin
        exp_px = expected_pixels.pop_front();
        want = '{exp_px.r, exp_px.g, exp_px.b};
        got  = '{red, green, blue};
        for (int i = 0; i < 3; i++) begin
          if (want[i] !== got[i]) begin
            $display("%0t: %s mismatch (h=%0d s=%0d v=%0d) expected %0d actual %0d",
                     $time, name[i], exp_px.hue, exp_px.sat, exp_px.val, want[i], got[i]);
            mismatches = mismatches + 1;
          end
        end
      end
    end
    in_flight = expected_pixels.size();
  end

endmodule

[test/hsv_to_rgb_pixel_converter_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_pixel_converter_test
// Drives HSV items into the converter: a directed set of hue, saturation and
// brightness corner cases, then randomized items with random idle gaps. A
// checker module compares every RGB result; the verdict is given here.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pixel_converter_test;
  import hsv2rgb_pkg::*;

  localparam int RANDOM_ITEMS = 2000;

  logic  clk = 1'b0;
  logic  rst;
  logic  start;
  logic  busy;
  hue_t  hue;
  chan_t saturation;
  chan_t brightness;
  logic  done;
  chan_t red;
  chan_t green;
  chan_t blue;
  int    mismatches;
  int    in_flight;

  always #4 clk = ~clk;

  hsv_to_rgb_pixel_converter u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue)
  );

  hsv_to_rgb_pixel_converter_check u_check (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .hue        (hue),
    .saturation (saturation),
    .brightness (brightness),
    .done       (done),
    .red        (red),
    .green      (green),
    .blue       (blue),
    .mismatches (mismatches),
    .in_flight  (in_flight)
  );

  // Idle for the gap with junk on the fields, then hold the item until taken.
  task automatic send_pixel(input int h, input int s, input int v, input int gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) begin
        hue        <= hue_t'($urandom);
        saturation <= chan_t'($urandom);
        brightness <= chan_t'($urandom);
        @(posedge clk);
      end
    end
    start      <= 1'b1;
    hue        <= hue_t'(h);
    saturation <= chan_t'(s);
    brightness <= chan_t'(v);
    do @(posedge clk); while (busy);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  initial begin
    int h;
    int s;
    int v;
    int kind;
    int gap;
    int waited;
    rst        = 1'b1;
    start      = 1'b0;
    hue        = '0;
    saturation = '0;
    brightness = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // zero saturation gives gray
    send_pixel(1234, 0, 200, 0);
    send_pixel(-32768, 0, 255, 0);
    // field extremes
    send_pixel(-32768, 255, 255, 0);
    send_pixel(32767, 255, 255, 0);
    send_pixel(32767, 1, 0, 0);
    send_pixel(0, 255, 0, 0);
    send_pixel(-1, 255, 255, 1);
    // one full turn, positive and negative, maps to zero, and just below one turn
    send_pixel(5760, 255, 255, 0);
    send_pixel(-5760, 200, 180, 0);
    send_pixel(5759, 255, 255, 0);
    // every sector at its start, some also at their end
    send_pixel(0, 255, 255, 0);
    send_pixel(959, 255, 255, 0);
    send_pixel(960, 255, 255, 0);
    send_pixel(1919, 128, 255, 2);
    send_pixel(1920, 255, 255, 0);
    send_pixel(2880, 255, 255, 0);
    send_pixel(3839, 77, 201, 0);
    send_pixel(3840, 255, 255, 0);
    send_pixel(4800, 255, 255, 0);
    send_pixel(5000, 1, 255, 0);
    send_pixel(-960, 255, 255, 0);
    send_pixel(-4800, 128, 128, 0);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      kind = $urandom_range(0, 9);
      h = int'(hue_t'($urandom));
      s = $urandom_range(0, 255);
      v = $urandom_range(0, 255);
      if (kind == 0) s = 0;
      if (kind == 1) s = 255;
      if (kind == 2 || kind == 3)
        h = $urandom_range(0, 6) * 960 + $urandom_range(0, 2) - 1
            + ($urandom_range(0, 10) - 5) * 5760;
      if (kind == 4) v = ($urandom_range(0, 1) == 0) ? 0 : 255;
      gap = ((i % 256) < 64) ? 0 : pick_gap();
      send_pixel(h, s, v, gap);
    end
    start <= 1'b0;

    waited = 0;
    while (in_flight != 0 && waited < 1000) begin
      @(posedge clk);
      waited++;
    end
    if (in_flight != 0) begin
      $display("** hsv_to_rgb_pixel_converter: FAILED **");
      $finish;
    end else begin
      repeat (20) @(posedge clk);
      if (mismatches == 0) begin
        $display("** hsv_to_rgb_pixel_converter: PASSED **");
      end else begin
        $display("** hsv_to_rgb_pixel_converter: FAILED **");
      end
      $finish;
    end
  end

  initial begin
    #2_000_000;
    $display("** hsv_to_rgb_pixel_converter: FAILED **");
    $finish;
  end

endmodule
